// ----- sv/watchdog_timed_unlock_prescaler_assert.svh -----
// assertion macros for the watchdog timed unlock prescaler
// included by the top level; needs nothing else
`ifndef WATCHDOG_TIMED_UNLOCK_PRESCALER_ASSERT_SVH
`define WATCHDOG_TIMED_UNLOCK_PRESCALER_ASSERT_SVH

// condition implies consequence in the same cycle
`define WTUP_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("wtup: same-cycle check failed");

// condition implies consequence in the next cycle
`define WTUP_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("wtup: next-cycle check failed");

`endif

// ----- sv/wtup_pkg.sv -----
// types and constants for the watchdog timed unlock prescaler
// no dependencies
package wtup_pkg;

  localparam int unsigned UNLOCK_CYCLES = 4;
  localparam int unsigned CNT_W         = 3;
  // bits above the highest selectable prescaler tap never matter
  localparam int unsigned PRESCALE_W    = 22;
  localparam int unsigned PRESCALE_LSB  = 14;

  localparam logic [CNT_W-1:0] UNLOCK_INIT = CNT_W'(UNLOCK_CYCLES);

  localparam int unsigned BIT_WDE  = 3;
  localparam int unsigned BIT_WDCE = 4;

  localparam logic [PRESCALE_W-1:0] PRESCALE_BASE = PRESCALE_W'(1) << PRESCALE_LSB;

  typedef struct packed {
    logic [7:0]  control_byte_seen;
    logic [7:0]  cpu_cycles;
    logic [15:0] elapsed_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] control_byte_value;
    logic       control_writeback;
    logic       illegal_change;
    logic       prescaler_advanced;
    logic       watchdog_reset;
  } out_item_t;

endpackage

// ----- sv/watchdog_timed_unlock_prescaler.sv -----
// watchdog with timed-sequence protected control byte and microsecond prescaler
// depends on wtup_pkg and watchdog_timed_unlock_prescaler_assert.svh

// One beat is accepted every cycle while the input is not stalled. A beat sits in
// the input register, where the protection rules, window countdown and prescaler add are
// evaluated against the stored state in a single pass; the result and the new
// state are registered together, so a result passes from the input register to the
// output register as the state updates, and the next beat sees the updated state immediately.
// Throughput is one beat per cycle, set by that single state update stage; a
// stall on the output holds both registers and back-pressures the input.
`include "watchdog_timed_unlock_prescaler_assert.svh"

module watchdog_timed_unlock_prescaler
  import wtup_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic                  fuse;
  logic [7:0]            accepted_control, accepted_control_next;
  logic [CNT_W-1:0]      unlock_countdown, unlock_countdown_next;
  logic [7:0]            time_fraction, time_fraction_next;
  logic [PRESCALE_W-1:0] prescale_count, prescale_count_next;

  logic      s1_valid;
  in_item_t  s1;
  out_item_t res;
  logic      advance;

  logic             opened;
  logic [7:0]       ctl;
  logic [16:0]      total;
  logic [8:0]       whole;
  logic [PRESCALE_W-1:0] limit;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fuse <= 1'b0;
    end else if (cfg_we) begin
      fuse <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  always_comb begin
    accepted_control_next = accepted_control;
    unlock_countdown_next = unlock_countdown;
    time_fraction_next    = time_fraction;
    prescale_count_next   = prescale_count;
    opened                = 1'b0;
    ctl                   = accepted_control;
    total                 = 17'(time_fraction) + 17'(s1.elapsed_time);
    whole                 = total[16:8];
    limit                 = PRESCALE_BASE << s1.control_byte_seen[2:0];
    res                   = '0;

    if (s1.cpu_cycles != 8'd0) begin
      ctl = s1.control_byte_seen;
      if (accepted_control != s1.control_byte_seen) begin
        priority if (accepted_control[BIT_WDCE]) begin
          // window open: take the change, keep change-enable set, force enable when the fuse is set
          ctl[BIT_WDCE] = 1'b1;
          if (fuse) begin
            ctl[BIT_WDE] = 1'b1;
          end
          accepted_control_next = ctl;
        end else if (s1.control_byte_seen[BIT_WDE] && s1.control_byte_seen[BIT_WDCE]) begin
          unlock_countdown_next           = UNLOCK_INIT;
          opened                          = 1'b1;
          accepted_control_next[BIT_WDCE] = 1'b1;
          ctl                             = accepted_control_next;
        end else begin
          // unauthorised change, restore the accepted value
          ctl                   = accepted_control;
          res.control_writeback = 1'b1;
        end
        res.illegal_change = (ctl != s1.control_byte_seen);
      end
      if (unlock_countdown_next != '0) begin
        if (!opened) begin
          unlock_countdown_next = (8'(unlock_countdown_next) > s1.cpu_cycles)
            ? unlock_countdown_next - CNT_W'(s1.cpu_cycles) : '0;
        end
        if (unlock_countdown_next == '0) begin
          ctl[BIT_WDCE]         = 1'b0;
          accepted_control_next = ctl;
          res.control_writeback = 1'b1;
        end
      end
    end

    limit = PRESCALE_BASE << ctl[2:0];
    if (!ctl[BIT_WDE]) begin
      prescale_count_next = '0;
    end else begin
      time_fraction_next = total[7:0];
      if (whole != 9'd0) begin
        prescale_count_next    = prescale_count + PRESCALE_W'(whole);
        res.prescaler_advanced = 1'b1;
        res.watchdog_reset     = |(prescale_count_next & limit);
      end
    end
    res.control_byte_value = ctl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_control <= '0;
      unlock_countdown <= '0;
      time_fraction    <= '0;
      prescale_count   <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        accepted_control <= accepted_control_next;
        unlock_countdown <= unlock_countdown_next;
        time_fraction    <= time_fraction_next;
        prescale_count   <= prescale_count_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  // a reset request is only raised on a beat that advanced the prescaler
  `WTUP_ASSERT_NOW(a_reset_needs_advance, clk, rst,
    out_valid && out_data.watchdog_reset, out_data.prescaler_advanced)
  // a write-back never carries change-enable
  `WTUP_ASSERT_NOW(a_writeback_wdce_clear, clk, rst,
    out_valid && out_data.control_writeback, !out_data.control_byte_value[BIT_WDCE])
  // the window countdown never exceeds its load value
  `WTUP_ASSERT_NOW(a_countdown_bound, clk, rst,
    unlock_countdown != '0, unlock_countdown <= UNLOCK_INIT)
  // every beat leaving the input register lands in the output register
  `WTUP_ASSERT_NEXT(a_advance_lands, clk, rst, advance, out_valid)

endmodule

// ----- tb/tb.sv -----
// self-checking bench for the watchdog timed unlock prescaler
// holds a predictor of the control byte protection and the prescaler
// depends on wtup_pkg and the watchdog_timed_unlock_prescaler rtl
module tb;
  import wtup_pkg::*;

  // predicts the result of every accepted beat and checks result beats in order
  class wdt_scoreboard;
    bit         fuse_on     = 1'b0;
    logic [7:0] held_ctl    = '0;
    logic [2:0] window_left = '0;
    logic [7:0] usec_frac   = '0;
    logic [31:0] presc_cnt  = '0;
    out_item_t  due_q[$];
    int         errors      = 0;

    function void set_fuse(bit v);
      fuse_on = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void note_step(in_item_t it);
      out_item_t   r;
      logic [7:0]  ctl;
      logic [16:0] total;
      logic [8:0]  whole;
      bit          opened;
      r      = '0;
      opened = 1'b0;
      if (it.cpu_cycles == 0) begin
        ctl = held_ctl;
      end else begin
        ctl = it.control_byte_seen;
        if (held_ctl != it.control_byte_seen) begin
          if (held_ctl[BIT_WDCE]) begin
            if (fuse_on) ctl[BIT_WDE] = 1'b1;
            ctl[BIT_WDCE] = 1'b1;
            held_ctl = ctl;
          end else if (it.control_byte_seen[BIT_WDE] && it.control_byte_seen[BIT_WDCE]) begin
            window_left = UNLOCK_INIT;
            opened = 1'b1;
            held_ctl[BIT_WDCE] = 1'b1;
            ctl = held_ctl;
          end else begin
            // change outside the window is undone in memory
            ctl = held_ctl;
            r.control_writeback = 1'b1;
          end
          r.illegal_change = (ctl != it.control_byte_seen);
        end
        if (window_left != 0) begin
          if (!opened)
            window_left = (window_left > it.cpu_cycles) ?
                          window_left - it.cpu_cycles[2:0] : 3'd0;
          if (window_left == 0) begin
            ctl[BIT_WDCE] = 1'b0;
            held_ctl = ctl;
            r.control_writeback = 1'b1;
          end
        end
      end
      if (!ctl[BIT_WDE]) begin
        presc_cnt = '0;
      end else begin
        total     = {9'd0, usec_frac} + {1'b0, it.elapsed_time};
        whole     = total[16:8];
        usec_frac = total[7:0];
        if (whole != 0) begin
          presc_cnt = presc_cnt + whole;
          r.prescaler_advanced = 1'b1;
          r.watchdog_reset = presc_cnt[PRESCALE_LSB + ctl[2:0]];
        end
      end
      r.control_byte_value = ctl;
      due_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, actual %h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_q.size() == 0) begin
        $error("result beat %h with nothing expected", got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      cmp_field("control_byte_value", want.control_byte_value, got.control_byte_value);
      cmp_field("control_writeback", want.control_writeback, got.control_writeback);
      cmp_field("illegal_change", want.illegal_change, got.illegal_change);
      cmp_field("prescaler_advanced", want.prescaler_advanced, got.prescaler_advanced);
      cmp_field("watchdog_reset", want.watchdog_reset, got.watchdog_reset);
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic      cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  wdt_scoreboard sb = new;
  bit long_hold_req = 1'b0;

  watchdog_timed_unlock_prescaler uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  // both beats are taken from pre-edge values
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_step(in_data);
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiving side, with one long hold-off on request
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = 300;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_step(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drive_step(input logic [7:0] seen, input logic [7:0] cyc,
                            input logic [15:0] el);
    in_item_t it;
    it.control_byte_seen = seen;
    it.cpu_cycles        = cyc;
    it.elapsed_time      = el;
    send_step(it);
  endtask

  task automatic drain_and_write_fuse(input bit v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_fuse(v);
  endtask

  // software-like traffic built on the currently accepted control byte
  function automatic in_item_t make_step();
    in_item_t   it;
    logic [7:0] held;
    logic [7:0] nv;
    int         r;
    held = sb.held_ctl;
    nv   = 8'($urandom);
    if ($urandom_range(0, 4) != 0) nv[BIT_WDE] = 1'b1;
    if ($urandom_range(0, 2) != 0) nv[2:0] = 3'd0;
    r = $urandom_range(0, 99);
    if (r < 45) it.control_byte_seen = held;
    else if (r < 60) it.control_byte_seen = nv | 8'h18;
    else if (r < 78) it.control_byte_seen = held[BIT_WDCE] ? nv : (nv | 8'h18);
    else if (r < 88) it.control_byte_seen = held ^ (8'd1 << $urandom_range(0, 7));
    else it.control_byte_seen = 8'($urandom);

    r = $urandom_range(0, 99);
    if (r < 8) it.cpu_cycles = 8'd0;
    else if (r < 70) it.cpu_cycles = 8'($urandom_range(1, 3));
    else if (r < 90) it.cpu_cycles = 8'($urandom_range(4, 16));
    else if (r < 95) it.cpu_cycles = 8'hff;
    else it.cpu_cycles = 8'($urandom);

    r = $urandom_range(0, 99);
    if (r < 10) it.elapsed_time = 16'($urandom_range(0, 255));
    else if (r < 60) it.elapsed_time = 16'($urandom_range(16'hf000, 16'hffff));
    else if (r < 70) it.elapsed_time = 16'hffff;
    else it.elapsed_time = 16'($urandom);
    return it;
  endfunction

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    drain_and_write_fuse(1'b0);
    drive_step(8'h00, 8'h00, 16'hffff);  // zero cycles
    drive_step(8'h00, 8'h01, 16'h0000);
    drive_step(8'h07, 8'h01, 16'h0100);  // locked change undone
    drive_step(8'hff, 8'hff, 16'hffff);  // window opens
    drive_step(8'h08, 8'h01, 16'h0080);  // change inside the window
    drive_step(8'h18, 8'h00, 16'h0080);  // carried fraction makes a whole microsecond
    drive_step(8'h18, 8'h02, 16'hffff);
    drive_step(8'h18, 8'h01, 16'h0000);  // window expires, no whole microsecond
    drive_step(8'h08, 8'h01, 16'h0001);
    drive_step(8'h08, 8'hff, 16'hffff);
    drive_step(8'h18, 8'h01, 16'h0000);
    drive_step(8'h00, 8'h01, 16'hffff);  // disable clears the prescaler
    drive_step(8'he7, 8'hff, 16'h0000);  // upper bits kept
    drive_step(8'he7, 8'h00, 16'h0000);

    drain_and_write_fuse(1'b1);
    drive_step(8'hff, 8'h01, 16'h0000);
    drive_step(8'h00, 8'h01, 16'h1234);  // fuse forces enable on
    drive_step(8'h18, 8'h03, 16'hffff);
    drive_step(8'h08, 8'h01, 16'hffff);

    for (int ph = 0; ph < 3; ph++) begin
      drain_and_write_fuse(ph == 1);
      if (ph == 0) long_hold_req = 1'b1;
      repeat (400) send_step(make_step());
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
